// ===== hdl/alob_pkg.sv =====
package alob_pkg;

    localparam int LEVELS_DEF  = 16;
    localparam int IMB_RESET   = 5;
    localparam int PRICE_W     = 32;
    localparam int QTY_W       = 32;
    localparam int ORD_W       = 16;
    localparam int IN_QTY_W    = 24;
    // top-N sums cover at most 31 levels of 32-bit quantity
    localparam int SUM_W       = 37;
    localparam int DIV_DW      = 56;
    localparam int DIV_VW      = SUM_W + 1;
    localparam int S_DATA_W    = 72;
    localparam int S_USER_W    = 4;
    localparam int M_DATA_W    = 184;

    typedef enum logic [2:0] {
        FUNC_ADD   = 3'd0,
        FUNC_RED   = 3'd1,
        FUNC_SET   = 3'd2,
        FUNC_CLR   = 3'd3,
        FUNC_DEPTH = 3'd4,
        FUNC_VWAP  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_FULL  = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SOP_NONE,
        SOP_INS,
        SOP_DEL,
        SOP_WR,
        SOP_CLR
    } t_side_op;

    typedef struct packed {
        t_side_op           op;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ORD_W-1:0]   orders;
    } t_side_cmd;

endpackage

// ===== hdl/alob_side.sv =====
module alob_side import alob_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF,
    parameter int IW     = $clog2(LEVELS),
    parameter int CW     = $clog2(LEVELS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_side_cmd          i_cmd,
    input  logic [IW-1:0]      i_pos,
    input  logic [IW-1:0]      i_idx,
    output logic [PRICE_W-1:0] o_price,
    output logic [QTY_W-1:0]   o_qty,
    output logic [ORD_W-1:0]   o_orders,
    output logic [PRICE_W-1:0] o_top_price,
    output logic [CW-1:0]      o_count
);

    logic [PRICE_W-1:0] r_price [LEVELS];
    logic [QTY_W-1:0]   r_qty   [LEVELS];
    logic [ORD_W-1:0]   r_ord   [LEVELS];
    logic [PRICE_W-1:0] n_price [LEVELS];
    logic [QTY_W-1:0]   n_qty   [LEVELS];
    logic [ORD_W-1:0]   n_ord   [LEVELS];
    logic [CW-1:0]      r_count, n_count;

    assign o_price     = r_price[i_idx];
    assign o_qty       = r_qty[i_idx];
    assign o_orders    = r_ord[i_idx];
    assign o_top_price = r_price[0];
    assign o_count     = r_count;

    // shift the table open or closed around the level position, write a level in place, or clear the count
    always_comb begin
        n_count = r_count;
        for (int j = 0; j < LEVELS; j++) begin
            n_price[j] = r_price[j];
            n_qty[j]   = r_qty[j];
            n_ord[j]   = r_ord[j];
            unique case (i_cmd.op)
                SOP_INS: begin
                    if (IW'(j) == i_pos) begin
                        n_price[j] = i_cmd.price;
                        n_qty[j]   = i_cmd.qty;
                        n_ord[j]   = i_cmd.orders;
                    end else if (j > 0 && IW'(j) > i_pos) begin
                        n_price[j] = r_price[j-1];
                        n_qty[j]   = r_qty[j-1];
                        n_ord[j]   = r_ord[j-1];
                    end
                end
                SOP_DEL: begin
                    if (j < LEVELS - 1 && IW'(j) >= i_pos) begin
                        n_price[j] = r_price[j+1];
                        n_qty[j]   = r_qty[j+1];
                        n_ord[j]   = r_ord[j+1];
                    end
                end
                SOP_WR: begin
                    if (IW'(j) == i_pos) begin
                        n_qty[j] = i_cmd.qty;
                        n_ord[j] = i_cmd.orders;
                    end
                end
                default: ;
            endcase
        end
        unique case (i_cmd.op)
            SOP_INS: n_count = r_count + CW'(1);
            SOP_DEL: n_count = r_count - CW'(1);
            SOP_CLR: n_count = '0;
            default: ;
        endcase
    end

    // hold table entries
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LEVELS; j++) begin
            r_price[j] <= n_price[j];
            r_qty[j]   <= n_qty[j];
            r_ord[j]   <= n_ord[j];
        end
    end

    // hold level count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/alob_div.sv =====
module alob_div import alob_pkg::*; #(
    parameter int DW = DIV_DW,
    parameter int VW = DIV_VW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CNW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CNW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [DW-1:0] r_quot;
    logic [VW:0]   trial;
    logic          fits;

    assign trial  = {r_rem, r_quot[DW-1]};
    assign fits   = trial >= {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_quot;

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(DW);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= fits ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
                r_quot <= {r_quot[DW-2:0], fits};
                r_cnt  <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/aggregated_limit_order_book_core.sv =====
// Sequence: a scan over the side's levels, an update, an imbalance sum over the top
//   levels of each side, the imbalance division and a registered result; a vwap
//   query adds a division of its own. The imbalance division is skipped when the
//   summed quantities are zero.
// Throughput: one item at a time, taken the cycle after the result is registered.
// Reset (i_rst_n low, synchronous) empties both sides and sets imbalance_levels to 5.
module aggregated_limit_order_book_core import alob_pkg::*; #(
    parameter int LEVELS_PER_SIDE = LEVELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // price[31:0], qty[55:32], orders[71:56]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // func[2:0], side[3]
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // top_bid_price[31:0], top_ask_price[63:32], bid_present[64], ask_present[65],
    // spread_ticks[98:66], mid_ticks[130:99], crossed[131], bid_level_count[136:132],
    // ask_level_count[141:137], imbalance[149:142], query_answer[181:150],
    // status[183:182]
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int L  = LEVELS_PER_SIDE;
    localparam int IW = $clog2(L);
    localparam int CW = $clog2(L + 1);
    localparam int MW = (CW > 5) ? CW : 5;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_APPLY, S_VSTART, S_VWAIT,
        S_IMB, S_ISTART, S_IWAIT, S_FIN
    } t_state;

    t_state r_state;

    logic [4:0]          r_imb_lvl;
    logic [2:0]          r_func;
    logic                r_side;
    logic [PRICE_W-1:0]  r_price;
    logic [IN_QTY_W-1:0] r_qty;
    logic [ORD_W-1:0]    r_ord;
    logic [CW-1:0]       r_i;
    logic                r_found;
    logic [IW-1:0]       r_k;
    logic                r_pos_set;
    logic [IW-1:0]       r_pos;
    logic                r_stop;
    logic [QTY_W-1:0]    r_sum;
    logic [IN_QTY_W-1:0] r_left;
    logic [55:0]         r_prod;
    logic [55:0]         r_acc;
    logic [SUM_W-1:0]    r_bq, r_aq;
    logic [31:0]         r_answer;
    t_status             r_status;
    logic [7:0]          r_imb;
    logic                r_tvalid;
    logic [M_DATA_W-1:0] r_tdata;

    // side table ports
    t_side_cmd           b_cmd, a_cmd;
    logic [IW-1:0]       cmd_pos, rd_idx;
    logic [PRICE_W-1:0]  b_price, a_price, b_top, a_top;
    logic [QTY_W-1:0]    b_qty, a_qty;
    logic [ORD_W-1:0]    b_ord, a_ord;
    logic [CW-1:0]       b_cnt, a_cnt;

    // selected side view
    logic [PRICE_W-1:0]  sel_price;
    logic [QTY_W-1:0]    sel_qty;
    logic [ORD_W-1:0]    sel_ord;
    logic [CW-1:0]       sel_cnt;

    // divider
    logic                div_start, div_done;
    logic [DIV_DW-1:0]   div_dividend, div_quot;
    logic [DIV_VW-1:0]   div_divisor;

    logic                in_acc;
    logic [IN_QTY_W-1:0] take;
    logic [QTY_W:0]      sum_ext;
    logic [55:0]         acc_final;
    logic [MW-1:0]       n_lvl, b_lim, a_lim, lim, i_ext;
    logic [SUM_W:0]      total;
    logic [SUM_W-1:0]    mag;
    logic [DIV_DW-1:0]   mag100;
    logic                bp, ap;
    logic [31:0]         bb, ba;
    logic [32:0]         spread, mid_sum;
    logic                crossed;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

    assign sel_price = r_side ? a_price : b_price;
    assign sel_qty   = r_side ? a_qty   : b_qty;
    assign sel_ord   = r_side ? a_ord   : b_ord;
    assign sel_cnt   = r_side ? a_cnt   : b_cnt;
    assign rd_idx    = (r_state == S_APPLY) ? r_k : r_i[IW-1:0];
    assign cmd_pos   = r_found ? r_k : (r_pos_set ? r_pos : sel_cnt[IW-1:0]);

    assign take    = (sel_qty < QTY_W'(r_left)) ? sel_qty[IN_QTY_W-1:0] : r_left;
    assign sum_ext = {1'b0, r_sum} + {1'b0, sel_qty};
    assign acc_final = r_acc + r_prod;

    // imbalance scan bounds: zero levels acts as one
    assign n_lvl = (r_imb_lvl == '0) ? MW'(1) : MW'(r_imb_lvl);
    assign b_lim = (MW'(b_cnt) < n_lvl) ? MW'(b_cnt) : n_lvl;
    assign a_lim = (MW'(a_cnt) < n_lvl) ? MW'(a_cnt) : n_lvl;
    assign lim   = (b_lim > a_lim) ? b_lim : a_lim;
    assign i_ext = MW'(r_i);

    assign total  = {1'b0, r_bq} + {1'b0, r_aq};
    assign mag    = (r_bq >= r_aq) ? (r_bq - r_aq) : (r_aq - r_bq);
    assign mag100 = (DIV_DW'(mag) << 6) + (DIV_DW'(mag) << 5) + (DIV_DW'(mag) << 2);

    assign div_start    = (r_state == S_VSTART) || (r_state == S_ISTART);
    assign div_dividend = (r_state == S_VSTART) ? r_acc : mag100;
    assign div_divisor  = (r_state == S_VSTART) ? DIV_VW'(r_qty) : total[DIV_VW-1:0];

    // top of book figures
    assign bp      = (b_cnt != '0);
    assign ap      = (a_cnt != '0);
    assign bb      = bp ? b_top : '0;
    assign ba      = ap ? a_top : '0;
    assign spread  = (bp && ap) ? ({1'b0, ba} - {1'b0, bb}) : '0;
    assign mid_sum = {1'b0, ba} + {1'b0, bb};
    assign crossed = bp && ap && (ba <= bb);

    // build the side command for the update
    always_comb begin
        t_side_cmd cmd;
        logic [QTY_W:0]   q_add;
        logic [ORD_W:0]   o_add;
        cmd.op     = SOP_NONE;
        cmd.price  = r_price;
        cmd.qty    = QTY_W'(r_qty);
        cmd.orders = r_ord;
        q_add = {1'b0, sel_qty} + (QTY_W + 1)'(r_qty);
        o_add = {1'b0, sel_ord} + {1'b0, r_ord};
        b_cmd = cmd;
        a_cmd = cmd;
        if (r_state == S_APPLY) begin
            unique case (r_func)
                FUNC_ADD: begin
                    if (r_found) begin
                        cmd.op     = SOP_WR;
                        cmd.qty    = q_add[QTY_W] ? '1 : q_add[QTY_W-1:0];
                        cmd.orders = o_add[ORD_W] ? '1 : o_add[ORD_W-1:0];
                    end else if (sel_cnt != CW'(L)) begin
                        cmd.op = SOP_INS;
                    end
                end
                FUNC_RED: begin
                    if (r_found) begin
                        if (QTY_W'(r_qty) >= sel_qty) begin
                            cmd.op = SOP_DEL;
                        end else begin
                            cmd.op     = SOP_WR;
                            cmd.qty    = sel_qty - QTY_W'(r_qty);
                            cmd.orders = (r_ord >= sel_ord) ? '0 : sel_ord - r_ord;
                        end
                    end
                end
                FUNC_SET: begin
                    if (r_qty == '0) begin
                        if (r_found) cmd.op = SOP_DEL;
                    end else if (r_found) begin
                        cmd.op = SOP_WR;
                    end else if (sel_cnt != CW'(L)) begin
                        cmd.op = SOP_INS;
                    end
                end
                FUNC_CLR: cmd.op = SOP_CLR;
                default: ;
            endcase
            if (r_func == FUNC_CLR) begin
                b_cmd = cmd;
                a_cmd = cmd;
            end else if (r_side) begin
                a_cmd = cmd;
            end else begin
                b_cmd = cmd;
            end
        end
    end

    alob_side #(.LEVELS(L), .IW(IW), .CW(CW)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(b_cmd), .i_pos(cmd_pos),
        .i_idx(rd_idx), .o_price(b_price), .o_qty(b_qty), .o_orders(b_ord),
        .o_top_price(b_top), .o_count(b_cnt)
    );

    alob_side #(.LEVELS(L), .IW(IW), .CW(CW)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(a_cmd), .i_pos(cmd_pos),
        .i_idx(rd_idx), .o_price(a_price), .o_qty(a_qty), .o_orders(a_ord),
        .o_top_price(a_top), .o_count(a_cnt)
    );

    alob_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_dividend), .i_divisor(div_divisor),
        .o_done(div_done), .o_quot(div_quot)
    );

    // hold configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imb_lvl <= 5'(IMB_RESET);
        end else if (i_cfg_we) begin
            r_imb_lvl <= i_cfg_wdata;
        end
    end

    // sequence one item through scan, update, divisions and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            if (r_tvalid && m_axis_tready && r_state != S_FIN) r_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func    <= s_axis_tuser[2:0];
                        r_side    <= s_axis_tuser[3];
                        r_price   <= s_axis_tdata[31:0];
                        r_qty     <= s_axis_tdata[55:32];
                        r_ord     <= s_axis_tdata[71:56];
                        r_i       <= '0;
                        r_found   <= 1'b0;
                        r_k       <= '0;
                        r_pos_set <= 1'b0;
                        r_pos     <= '0;
                        r_stop    <= 1'b0;
                        r_sum     <= '0;
                        r_left    <= s_axis_tdata[55:32];
                        r_prod    <= '0;
                        r_acc     <= '0;
                        r_answer  <= '0;
                        r_status  <= ST_OK;
                        r_imb     <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_i < sel_cnt) begin
                        if (!r_found && sel_price == r_price) begin
                            r_found <= 1'b1;
                            r_k     <= r_i[IW-1:0];
                        end
                        if (!r_pos_set && (r_side ? (r_price < sel_price)
                                                  : (r_price > sel_price))) begin
                            r_pos_set <= 1'b1;
                            r_pos     <= r_i[IW-1:0];
                        end
                        if (!r_stop) begin
                            if (r_side ? (sel_price > r_price) : (sel_price < r_price)) begin
                                r_stop <= 1'b1;
                            end else begin
                                r_sum <= sum_ext[QTY_W] ? '1 : sum_ext[QTY_W-1:0];
                            end
                        end
                        // accumulate the previous product, form the next
                        r_acc  <= acc_final;
                        r_prod <= (r_left != '0) ? 56'(take) * 56'(sel_price) : '0;
                        r_left <= r_left - take;
                    end
                    r_i <= r_i + CW'(1);
                    if ((r_i + CW'(1)) >= sel_cnt) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_i     <= '0;
                    r_bq    <= '0;
                    r_aq    <= '0;
                    r_state <= S_IMB;
                    unique case (r_func)
                        FUNC_ADD: begin
                            if (!r_found && sel_cnt == CW'(L)) r_status <= ST_FULL;
                        end
                        FUNC_RED: begin
                            if (!r_found) r_status <= ST_STALE;
                        end
                        FUNC_SET: begin
                            if (r_qty != '0 && !r_found && sel_cnt == CW'(L))
                                r_status <= ST_FULL;
                        end
                        FUNC_DEPTH: r_answer <= r_sum;
                        FUNC_VWAP: begin
                            if (r_qty != '0) begin
                                if (r_left != '0) begin
                                    r_status <= ST_SHORT;
                                end else begin
                                    r_acc   <= acc_final;
                                    r_state <= S_VSTART;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_VSTART: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (div_done) begin
                        r_answer <= div_quot[31:0];
                        r_state  <= S_IMB;
                    end
                end
                S_IMB: begin
                    if (i_ext < b_lim) r_bq <= r_bq + SUM_W'(b_qty);
                    if (i_ext < a_lim) r_aq <= r_aq + SUM_W'(a_qty);
                    r_i <= r_i + CW'(1);
                    if ((i_ext + MW'(1)) >= lim || r_i == CW'(L - 1)) r_state <= S_ISTART;
                end
                S_ISTART: begin
                    // skip the division when the summed quantities are zero
                    r_state <= (total == '0) ? S_FIN : S_IWAIT;
                end
                S_IWAIT: begin
                    if (div_done) begin
                        r_imb   <= (r_bq >= r_aq) ? {1'b0, div_quot[6:0]}
                                                  : 8'(0) - {1'b0, div_quot[6:0]};
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_tvalid || m_axis_tready) begin
                        r_tvalid <= 1'b1;
                        r_tdata  <= {r_status, r_answer, r_imb, 5'(a_cnt),
                                     5'(b_cnt), crossed,
                                     (bp && ap) ? mid_sum[32:1] : 32'd0,
                                     spread, ap, bp, ba, bb};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
